FILE: rtl/core/wmd_pkg.sv
// ----------------------------------------------------------------------------
// Waveform min/max decimator package
// Shared widths, constants, configuration indexes and divider status type.
// ----------------------------------------------------------------------------
`default_nettype none

package wmd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 20;
  localparam int CCOUNT_W    = 13;
  localparam int COL_W       = 12;
  localparam int MAX_COLUMNS = 4096;
  localparam int PEAK_RATIO  = 5;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int DIV_CNT_W   = $clog2(POS_W);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WINDOW_START  = 2'd0,
    CFG_WINDOW_LENGTH = 2'd1,
    CFG_COLUMN_COUNT  = 2'd2,
    CFG_PEAK_ENABLE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/wmd_if.sv
// ----------------------------------------------------------------------------
// Waveform min/max decimator channels
// Valid/ready request channels for input samples and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [wmd_pkg::SAMPLE_W-1:0] sample;
  logic                                restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface wmd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wmd_pkg::SAMPLE_W-1:0] column_max;
  logic signed [wmd_pkg::SAMPLE_W-1:0] column_min;
  logic        [wmd_pkg::POS_W-1:0]    out_index;
  logic                                is_peak;
  logic                                last;

  modport source (output valid, column_max, column_min, out_index, is_peak, last,
                  input ready);
  modport sink   (input valid, column_max, column_min, out_index, is_peak, last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wmd_div.sv
// ----------------------------------------------------------------------------
// Waveform min/max decimator interval divider
// Restoring divider, one quotient bit per cycle, for the column interval.
// ----------------------------------------------------------------------------
`default_nettype none

module wmd_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [wmd_pkg::POS_W-1:0]     dividend,
  input  wire logic [wmd_pkg::CCOUNT_W-1:0]  divisor,
  output logic      [wmd_pkg::POS_W-1:0]     quotient,
  output wmd_pkg::div_stat_t                 stat
);

  logic [wmd_pkg::CCOUNT_W-1:0]  rem_r, rem_nxt;
  logic [wmd_pkg::POS_W-1:0]     quo_r, quo_nxt;
  logic [wmd_pkg::CCOUNT_W-1:0]  dvs_r, dvs_nxt;
  logic [wmd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [wmd_pkg::CCOUNT_W:0]    trial;
  logic [wmd_pkg::CCOUNT_W:0]    diff;
  logic                          qbit;

  always_comb begin
    trial    = {rem_r, quo_r[wmd_pkg::POS_W-1]};
    diff     = trial - {1'b0, dvs_r};
    qbit     = (trial >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[wmd_pkg::CCOUNT_W-1:0] : trial[wmd_pkg::CCOUNT_W-1:0];
      quo_nxt = {quo_r[wmd_pkg::POS_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == wmd_pkg::DIV_CNT_W'(wmd_pkg::POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

FILE: rtl/core/waveform_minmax_decimator.sv
// ----------------------------------------------------------------------------
// Waveform min/max decimator
// Selects a view window of a sample stream and reduces it to per-column
// min/max pairs, or passes the window samples through.
// ----------------------------------------------------------------------------
// Samples arrive on in_chan as requests with a restart flag on the first
// sample of an array; results leave on out_chan, at most one per sample.
// The user must write registers over cfg_we/cfg_addr/cfg_wdata only while the
// block idles; the block does not enforce it. A sample without restart has its
// result loaded into the output register at the edge that takes it, so such
// samples stream at one per cycle while the output register is free.
// A restart sample runs the restoring divider for the column interval:
// one quotient bit per cycle, POS_W bits. The block waits in ST_DIV until the
// divider is done, then in ST_PROC handles the sample itself once the output
// register is free, and returns to ST_IDLE, where the next request is taken.
// The output register is a single stage: a request is taken while a result
// waits only if that result leaves in the same cycle, so a stalled receiver
// holds the input side after one buffered result.
// Reset restores the register defaults (start 0, length 1, one column, peak
// allowed), counts from position 0 in pass-through mode and empties the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_minmax_decimator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [wmd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [wmd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  wmd_in_if.sink                               in_chan,
  wmd_out_if.source                            out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PROC = 3'b100
  } state_t;

  localparam logic signed [wmd_pkg::SAMPLE_W-1:0] SMP_MIN =
    {1'b1, {(wmd_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [wmd_pkg::SAMPLE_W-1:0] SMP_MAX =
    {1'b0, {(wmd_pkg::SAMPLE_W-1){1'b1}}};

  state_t state_r, state_nxt;

  logic [wmd_pkg::POS_W-1:0]    wstart_r;
  logic [wmd_pkg::POS_W-1:0]    wlength_r;
  logic [wmd_pkg::CCOUNT_W-1:0] ccount_r;
  logic                         peak_en_r;

  logic [wmd_pkg::POS_W-1:0]           pos_r, pos_nxt;
  logic [wmd_pkg::COL_W-1:0]           col_r, col_nxt;
  logic [wmd_pkg::POS_W-1:0]           cnt_r, cnt_nxt;
  logic [wmd_pkg::POS_W-1:0]           interval_r, interval_nxt;
  logic signed [wmd_pkg::SAMPLE_W-1:0] rmax_r, rmax_nxt;
  logic signed [wmd_pkg::SAMPLE_W-1:0] rmin_r, rmin_nxt;
  logic                                peak_r, peak_nxt;
  logic signed [wmd_pkg::SAMPLE_W-1:0] smp_r;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [wmd_pkg::SAMPLE_W-1:0] out_max_r, out_min_r;
  logic [wmd_pkg::POS_W-1:0]           out_idx_r;
  logic                                out_peak_r, out_last_r;

  logic                                out_free, accept, restart_acc, step;
  logic signed [wmd_pkg::SAMPLE_W-1:0] cur;
  logic [wmd_pkg::POS_W:0]             pos_end;
  logic [wmd_pkg::POS_W:0]             five_c;
  logic                                peak_ok;
  logic                                in_norm, in_peak, last_norm, last_peak;
  logic                                col_last, col_done;
  logic [wmd_pkg::POS_W-1:0]           cnt_inc;
  logic signed [wmd_pkg::SAMPLE_W-1:0] max_new, min_new;
  logic                                res_valid;
  logic signed [wmd_pkg::SAMPLE_W-1:0] res_max, res_min;
  logic [wmd_pkg::POS_W-1:0]           res_idx;
  logic                                res_peak, res_last;

  logic [wmd_pkg::POS_W-1:0] div_q;
  wmd_pkg::div_stat_t        div_st;

  wmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (restart_acc),
    .dividend (wlength_r),
    .divisor  (ccount_r),
    .quotient (div_q),
    .stat     (div_st)
  );

  assign out_free       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE) && out_free;
  assign accept         = in_chan.valid && in_chan.ready;
  assign restart_acc    = accept && in_chan.restart;
  assign step           = (accept && !in_chan.restart) ||
                          ((state_r == ST_PROC) && out_free);
  assign cur            = (state_r == ST_PROC) ? smp_r : in_chan.sample;

  always_comb begin
    five_c  = {{(wmd_pkg::POS_W+1-wmd_pkg::CCOUNT_W-2){1'b0}}, ccount_r, 2'b00} +
              {{(wmd_pkg::POS_W+1-wmd_pkg::CCOUNT_W){1'b0}}, ccount_r};
    peak_ok = peak_en_r && (ccount_r != '0) &&
              (ccount_r <= wmd_pkg::CCOUNT_W'(wmd_pkg::MAX_COLUMNS)) &&
              ({1'b0, wlength_r} >= five_c);

    pos_end   = {1'b0, wstart_r} + {1'b0, wlength_r};
    in_norm   = (pos_r >= wstart_r) && ({1'b0, pos_r} <= pos_end);
    last_norm = ({1'b0, pos_r} == pos_end);
    in_peak   = (pos_r >= wstart_r) && ({1'b0, pos_r} < pos_end);
    last_peak = (({1'b0, pos_r} + 1'b1) == pos_end);

    col_last = (ccount_r == '0) || (({1'b0, col_r} + 1'b1) >= ccount_r);
    cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    col_done = col_last ? last_peak : (cnt_inc >= interval_r);
    max_new  = (cur > rmax_r) ? cur : rmax_r;
    min_new  = (cur < rmin_r) ? cur : rmin_r;

    res_valid = 1'b0;
    res_max   = cur;
    res_min   = cur;
    res_idx   = pos_r - wstart_r;
    res_peak  = 1'b0;
    res_last  = last_norm;

    pos_nxt      = pos_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    rmax_nxt     = rmax_r;
    rmin_nxt     = rmin_r;
    peak_nxt     = peak_r;
    interval_nxt = interval_r;

    if (div_st.done) begin
      interval_nxt = peak_r ? div_q : '0;
    end

    if (restart_acc) begin
      pos_nxt  = '0;
      col_nxt  = '0;
      cnt_nxt  = '0;
      rmax_nxt = SMP_MIN;
      rmin_nxt = SMP_MAX;
      peak_nxt = peak_ok;
    end else if (step) begin
      if (pos_r != '1) begin
        pos_nxt = pos_r + 1'b1;
        if (!peak_r) begin
          res_valid = in_norm;
        end else if (in_peak) begin
          rmax_nxt = max_new;
          rmin_nxt = min_new;
          cnt_nxt  = cnt_inc;
          if (col_done) begin
            res_valid = 1'b1;
            res_max   = max_new;
            res_min   = min_new;
            res_idx   = {{(wmd_pkg::POS_W-wmd_pkg::COL_W){1'b0}}, col_r};
            res_peak  = 1'b1;
            res_last  = col_last;
            col_nxt   = col_r + 1'b1;
            cnt_nxt   = '0;
            rmax_nxt  = SMP_MIN;
            rmin_nxt  = SMP_MAX;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (restart_acc) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) state_nxt = ST_PROC;
      end
      ST_PROC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wstart_r    <= '0;
      wlength_r   <= wmd_pkg::POS_W'(1);
      ccount_r    <= wmd_pkg::CCOUNT_W'(1);
      peak_en_r   <= 1'b1;
      pos_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      interval_r  <= '0;
      rmax_r      <= SMP_MIN;
      rmin_r      <= SMP_MAX;
      peak_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      interval_r  <= interval_nxt;
      rmax_r      <= rmax_nxt;
      rmin_r      <= rmin_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (wmd_pkg::cfg_idx_t'(cfg_addr))
          wmd_pkg::CFG_WINDOW_START:  wstart_r  <= cfg_wdata[wmd_pkg::POS_W-1:0];
          wmd_pkg::CFG_WINDOW_LENGTH: wlength_r <= cfg_wdata[wmd_pkg::POS_W-1:0];
          wmd_pkg::CFG_COLUMN_COUNT:  ccount_r  <= cfg_wdata[wmd_pkg::CCOUNT_W-1:0];
          wmd_pkg::CFG_PEAK_ENABLE:   peak_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) smp_r <= in_chan.sample;
    if (step && res_valid) begin
      out_max_r  <= res_max;
      out_min_r  <= res_min;
      out_idx_r  <= res_idx;
      out_peak_r <= res_peak;
      out_last_r <= res_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.column_max = out_max_r;
  assign out_chan.column_min = out_min_r;
  assign out_chan.out_index  = out_idx_r;
  assign out_chan.is_peak    = out_peak_r;
  assign out_chan.last       = out_last_r;

  a_restart_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    restart_acc |=> (state_r == ST_DIV))
    else $error("restart request did not start the interval division");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division state");

  a_no_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (div_st.busy || state_r == ST_PROC) |-> !in_chan.ready)
    else $error("request taken while a restart is in progress");

  a_pass_column_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !peak_r |-> (col_r == '0))
    else $error("column number advanced in pass-through mode");

  a_no_peak_result_outside_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res_peak) |-> peak_r)
    else $error("min/max pair produced in pass-through mode");

endmodule

`default_nettype wire
